/* design/tda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_pkg
// Shared types, widths and the digest fold used by the tile digest blocks.
// ----------------------------------------------------------------------------
package tda_pkg;

    localparam int DIGEST_BYTES = 20;
    localparam int DIGEST_W     = 8 * DIGEST_BYTES;
    localparam int COORD_W      = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int GRID_W       = 4;
    localparam int S_TDATA_W    = 256;
    localparam int M_TDATA_W    = DIGEST_W;
    localparam int DIV_STEPS    = CFG_W;

    typedef enum logic {
        KIND_ADD  = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_GRID_COLS    = 2'd2,
        CFG_GRID_ROWS    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic signed [COORD_W-1:0] rect_w;
        logic signed [COORD_W-1:0] rect_h;
        logic        [DIGEST_W-1:0] hash;
    } t_add_req;

    // rotate by one byte toward byte 0 (byte 0 wraps to the top byte), then xor
    function automatic logic [DIGEST_W-1:0] fold_digest(
        input logic [DIGEST_W-1:0] cur,
        input logic [DIGEST_W-1:0] hash
    );
        logic [DIGEST_W-1:0] rot;
        rot = {cur[7:0], cur[8*DIGEST_BYTES-1:8]};
        return rot ^ hash;
    endfunction

endpackage

/* design/tda_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tda_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tda_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_front
// Takes input beats, sorts add from read and clamps the read tile into an index.
// ----------------------------------------------------------------------------
module tda_front
    import tda_pkg::*;
#(
    parameter int MAX_COLS = 8,
    parameter int MAX_ROWS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [$clog2(MAX_COLS+1)-1:0]       i_cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]       i_rows,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [S_TDATA_W-1:0]                i_data,
    input  logic                                i_user,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1+((MAX_COLS*MAX_ROWS > 1) ? $clog2(MAX_COLS*MAX_ROWS) : 1)
                  +$bits(t_add_req)-1:0]        o_data
);

    localparam int TILE_COUNT = MAX_COLS * MAX_ROWS;
    localparam int AW   = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int CCW  = $clog2(MAX_COLS + 1);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MW   = RIW + CCW;
    localparam int EW   = 1 + AW + $bits(t_add_req);
    localparam logic [AW-1:0] IDX_MASK = AW'(TILE_COUNT - 1);

    // field positions inside tdata
    localparam int POS_HASH = 4 * COORD_W;
    localparam int POS_COL  = POS_HASH + DIGEST_W;
    localparam int POS_ROW  = POS_COL + COORD_W;

    logic [EW-1:0]             r_data;
    logic                      r_valid;
    logic                      accept;
    t_kind                     kind;
    t_add_req                  add_req;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic [CIW-1:0]            col_c;
    logic [RIW-1:0]            row_c;
    logic [MW-1:0]             lin;
    logic [AW-1:0]             idx;
    logic [EW-1:0]             n_data;

    assign kind            = t_kind'(i_user);
    assign add_req.rect_x  = i_data[0*COORD_W +: COORD_W];
    assign add_req.rect_y  = i_data[1*COORD_W +: COORD_W];
    assign add_req.rect_w  = i_data[2*COORD_W +: COORD_W];
    assign add_req.rect_h  = i_data[3*COORD_W +: COORD_W];
    assign add_req.hash    = i_data[POS_HASH +: DIGEST_W];
    assign col             = i_data[POS_COL +: COORD_W];
    assign row             = i_data[POS_ROW +: COORD_W];

    always_comb begin
        if (col[COORD_W-1]) begin
            col_c = '0;
        end else if (COORD_W'(col) >= COORD_W'(i_cols)) begin
            col_c = CIW'(i_cols - CCW'(1));
        end else begin
            col_c = CIW'(col);
        end
        if (row[COORD_W-1]) begin
            row_c = '0;
        end else if (COORD_W'(row) >= COORD_W'(i_rows)) begin
            row_c = RIW'(i_rows - RCW'(1));
        end else begin
            row_c = RIW'(row);
        end
    end

    // entry = row * cols + col, folded like the store addressing
    assign lin    = MW'(row_c) * MW'(i_cols) + MW'(col_c);
    assign idx    = lin[AW-1:0] & IDX_MASK;
    assign n_data = {kind, idx, add_req};

    assign o_ready = i_en && (!r_valid || i_ready);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* design/tda_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_queue
// Short first-in first-out queue between the front and back halves.
// ----------------------------------------------------------------------------
module tda_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [NW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != NW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + NW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - NW'(1);
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

/* design/tda_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_back
// Carries out queued requests: clear pass, tile size divide, tile walk, reads.
// ----------------------------------------------------------------------------
module tda_back
    import tda_pkg::*;
#(
    parameter int MAX_COLS = 8,
    parameter int MAX_ROWS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [CFG_W-1:0]                    i_frame_width,
    input  logic [CFG_W-1:0]                    i_frame_height,
    input  logic [$clog2(MAX_COLS+1)-1:0]       i_cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]       i_rows,
    input  logic                                i_q_valid,
    output logic                                o_q_pop,
    input  logic [1+((MAX_COLS*MAX_ROWS > 1) ? $clog2(MAX_COLS*MAX_ROWS) : 1)
                  +$bits(t_add_req)-1:0]        i_q_data,
    output logic                                o_items_en,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [M_TDATA_W-1:0]                o_data
);

    localparam int TILE_COUNT = MAX_COLS * MAX_ROWS;
    localparam int AW   = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int CCW  = $clog2(MAX_COLS + 1);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int PW   = COORD_W + 1 + $clog2(MAX_DIM + 1);
    localparam int EW   = 1 + AW + $bits(t_add_req);
    localparam int SW   = $clog2(DIV_STEPS);
    localparam logic [AW-1:0] IDX_MASK = AW'(TILE_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_WALK,
        S_RD,
        S_RDATA
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr;
    logic [SW-1:0]         r_cnt;
    logic [CFG_W-1:0]      r_qw;
    logic [CFG_W-1:0]      r_qh;
    logic [CCW-1:0]        r_rw;
    logic [RCW-1:0]        r_rh;
    logic signed [PW-1:0]  r_ax;
    logic signed [PW-1:0]  r_ay;
    logic signed [PW-1:0]  r_axe;
    logic signed [PW-1:0]  r_aye;
    logic [DIGEST_W-1:0]   r_hash;
    logic [CIW-1:0]        r_c;
    logic [RIW-1:0]        r_r;
    logic [AW-1:0]         r_t;
    logic signed [PW-1:0]  r_xlo;
    logic signed [PW-1:0]  r_ylo;
    logic                  r_b_valid;
    logic [AW-1:0]         r_b_idx;
    logic                  r_b_fwd;
    logic [DIGEST_W-1:0]   r_wlast;
    logic [AW-1:0]         r_ridx;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out;

    t_kind                 head_kind;
    logic [AW-1:0]         head_idx;
    t_add_req              head_add;

    logic [CCW:0]          wsh;
    logic [RCW:0]          hsh;
    logic                  wge;
    logic                  hge;
    logic [CCW-1:0]        n_rw;
    logic [RCW-1:0]        n_rh;

    logic signed [PW-1:0]  tw_s;
    logic signed [PW-1:0]  th_s;
    logic signed [PW-1:0]  xhi;
    logic signed [PW-1:0]  yhi;
    logic                  overlap;
    logic                  col_last;
    logic                  row_last;
    logic [AW-1:0]         idx_a;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DIGEST_W-1:0]   ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DIGEST_W-1:0]   ram_q;
    logic [DIGEST_W-1:0]   cur;
    logic [DIGEST_W-1:0]   n_digest;
    logic                  load_out;

    assign head_kind = t_kind'(i_q_data[EW-1]);
    assign head_idx  = i_q_data[EW-2 -: AW];
    assign head_add  = t_add_req'(i_q_data[$bits(t_add_req)-1:0]);

    // one restoring step each for tile width and tile height
    assign wsh  = {r_rw, r_qw[CFG_W-1]};
    assign hsh  = {r_rh, r_qh[CFG_W-1]};
    assign wge  = (wsh >= {1'b0, i_cols});
    assign hge  = (hsh >= {1'b0, i_rows});
    assign n_rw = CCW'(wge ? wsh - {1'b0, i_cols} : wsh);
    assign n_rh = RCW'(hge ? hsh - {1'b0, i_rows} : hsh);

    // half-open overlap of the shape against the current tile
    assign tw_s    = signed'(PW'(r_qw));
    assign th_s    = signed'(PW'(r_qh));
    assign xhi     = r_xlo + tw_s;
    assign yhi     = r_ylo + th_s;
    assign overlap = !((r_ax >= xhi) || (r_xlo >= r_axe) ||
                       (r_ay >= yhi) || (r_ylo >= r_aye));
    assign col_last = (r_c == CIW'(i_cols - CCW'(1)));
    assign row_last = (r_r == RIW'(i_rows - RCW'(1)));
    assign idx_a    = r_t & IDX_MASK;

    assign cur      = r_b_fwd ? r_wlast : ram_q;
    assign n_digest = fold_digest(cur, r_hash);

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = idx_a;
        if (r_state == S_WALK) begin
            ram_re = overlap;
        end else if (r_state == S_RD) begin
            ram_re    = 1'b1;
            ram_raddr = r_ridx;
        end
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_b_valid;
            ram_waddr = r_b_idx;
            ram_wdata = n_digest;
        end
    end

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_items_en = (r_state != S_CLEAR);
    assign load_out   = (r_state == S_RDATA) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_b_valid <= (r_state == S_WALK) && overlap;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == IDX_MASK) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= (head_kind == KIND_READ) ? S_RD : S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (col_last && row_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        // datapath
        r_b_idx <= idx_a;
        r_b_fwd <= r_b_valid && (r_b_idx == idx_a);
        if (r_b_valid) begin
            r_wlast <= n_digest;
        end
        if (load_out) begin
            r_out <= ram_q;
        end
        case (r_state)
            S_IDLE: begin
                r_ridx <= head_idx;
                r_hash <= head_add.hash;
                r_ax   <= PW'(head_add.rect_x);
                r_ay   <= PW'(head_add.rect_y);
                r_axe  <= PW'(head_add.rect_x) + PW'(head_add.rect_w);
                r_aye  <= PW'(head_add.rect_y) + PW'(head_add.rect_h);
                r_qw   <= i_frame_width;
                r_qh   <= i_frame_height;
                r_rw   <= '0;
                r_rh   <= '0;
                r_cnt  <= SW'(DIV_STEPS - 1);
            end
            S_DIV: begin
                r_qw  <= {r_qw[CFG_W-2:0], wge};
                r_qh  <= {r_qh[CFG_W-2:0], hge};
                r_rw  <= n_rw;
                r_rh  <= n_rh;
                r_cnt <= r_cnt - SW'(1);
                r_c   <= '0;
                r_r   <= '0;
                r_t   <= '0;
                r_xlo <= '0;
                r_ylo <= '0;
            end
            S_WALK: begin
                r_t <= r_t + AW'(1);
                if (col_last) begin
                    r_c   <= '0;
                    r_xlo <= '0;
                    r_r   <= r_r + RIW'(1);
                    r_ylo <= yhi;
                end else begin
                    r_c   <= r_c + CIW'(1);
                    r_xlo <= xhi;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    tda_ram #(.WIDTH(64), .DEPTH(TILE_COUNT)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata[63:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q[63:0])
    );

    tda_ram #(.WIDTH(64), .DEPTH(TILE_COUNT)) u_ram_mid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata[127:64]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q[127:64])
    );

    tda_ram #(.WIDTH(32), .DEPTH(TILE_COUNT)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata[159:128]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q[159:128])
    );

endmodule

/* design/tile_digest_accumulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_digest_accumulator
// Per-tile 160-bit digest store over a frame grid, with add and read beats.
// ----------------------------------------------------------------------------
// The frame is split into grid_cols by grid_rows tiles of
// (frame_width / cols) by (frame_height / rows) pixels, each holding a 20-byte
// digest. An add beat (tuser 0) carries a shape rectangle and hash; every
// tile it overlaps gets its digest rotated one byte toward byte 0 and xored
// with the hash. A read beat (tuser 1) clamps its column and row into the
// grid and returns that tile's digest as one beat. After reset a clearing
// pass zeroes the store, one entry a cycle, during which s_axis_tready
// stays low. An add is dequeued by the back end, runs a bit-serial divide
// that finds the tile size, then walks the tiles in row-major order. A
// read is dequeued, reads the digest RAM and loads the output register. A
// two-entry queue between front and back lets new beats arrive while the
// back end works, and the output register holds a result until it is
// taken. Config writes take effect at once and do not clear the store.
// ----------------------------------------------------------------------------
module tile_digest_accumulator
    import tda_pkg::*;
#(
    parameter int MAX_COLS = 8,
    parameter int MAX_ROWS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request beats
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, hash_lo, hash_mid, hash_hi, tile_col, tile_row
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [0:0]           s_axis_tuser,
    // result beats
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // digest_lo, digest_mid, digest_hi
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int TILE_COUNT = MAX_COLS * MAX_ROWS;
    localparam int AW  = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int EW  = 1 + AW + $bits(t_add_req);

    // config registers
    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [GRID_W-1:0] r_grid_cols;
    logic [GRID_W-1:0] r_grid_rows;

    // grid size in use after clamping
    logic [CCW-1:0]    cols;
    logic [RCW-1:0]    rows;

    // front to queue
    logic              fr_valid;
    logic              fr_ready;
    logic [EW-1:0]     fr_data;

    // queue to back
    logic              q_valid;
    logic              q_pop;
    logic [EW-1:0]     q_data;

    logic              items_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
            r_grid_cols    <= GRID_W'(8);
            r_grid_rows    <= GRID_W'(8);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_GRID_COLS:    r_grid_cols    <= i_cfg_data[GRID_W-1:0];
                CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data[GRID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero counts as one, anything past the maximum as the maximum
    always_comb begin
        if (r_grid_cols == '0) begin
            cols = CCW'(1);
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            cols = CCW'(MAX_COLS);
        end else begin
            cols = CCW'(r_grid_cols);
        end
        if (r_grid_rows == '0) begin
            rows = RCW'(1);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            rows = RCW'(MAX_ROWS);
        end else begin
            rows = RCW'(r_grid_rows);
        end
    end

    tda_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (items_en),
        .i_cols  (cols),
        .i_rows  (rows),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser[0]),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_data  (fr_data)
    );

    tda_queue #(.WIDTH(EW), .DEPTH(2)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_data  (fr_data),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_data   (q_data)
    );

    tda_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_cols         (cols),
        .i_rows         (rows),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_data       (q_data),
        .o_items_en     (items_en),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data         (m_axis_tdata)
    );

endmodule

/* design/tda_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_checker
// Port-level checks on the tile digest accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module tda_checker
    import tda_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // reset empties the output and closes the input for the clearing pass
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("block not quiet right after reset");

    // a result beat only rises once reset has stayed released
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(i_rst_n, 1) && $past(i_rst_n, 2) &&
                                 $past(i_rst_n, 3))
        else $error("result beat too soon after reset");

endmodule

bind tile_digest_accumulator tda_checker u_tda_checker (.*);

/* verif/tile_digest_accumulator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_digest_accumulator_tb
// Self-checking bench for the tile digest store with add and read beats.
// ----------------------------------------------------------------------------
// Request beats come from a directed opening at the reset grid, then random
// well-formed adds and reads mixed with noise beats under several frame and
// grid settings. The settings include one-pixel frames, full-range frames,
// zero-size tiles and out-of-range grid sizes. A scoreboard keeps its own
// copy of the digest store and the registers. Each accepted request updates
// that copy, and each read leaves an expected digest in a queue. Result
// beats are compared against the queue in order. Both sides idle at random.
// The receiver also holds off twice for a long stretch so that the input
// stalls.
// ----------------------------------------------------------------------------
module tile_digest_accumulator_tb;
    import tda_pkg::*;

    localparam int GRID_MAX      = 8;
    localparam int TILE_SLOTS    = GRID_MAX * GRID_MAX;
    // field positions in the request tdata, lowest first
    localparam int X_LSB         = 0;
    localparam int Y_LSB         = 16;
    localparam int W_LSB         = 32;
    localparam int H_LSB         = 48;
    localparam int HASH_LSB      = 64;
    localparam int COL_LSB       = 224;
    localparam int ROW_LSB       = 240;
    // worst backlog: three waiting adds plus one in the back end
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 600;

    // ------------------------------------------------------------------------
    // digest store predictor and expected read results
    // ------------------------------------------------------------------------
    class tile_digest_scoreboard;
        logic [DIGEST_W-1:0] tile_digest [TILE_SLOTS];
        logic [CFG_W-1:0]    frame_w;
        logic [CFG_W-1:0]    frame_h;
        logic [GRID_W-1:0]   cols_reg;
        logic [GRID_W-1:0]   rows_reg;
        logic [DIGEST_W-1:0] digests_due [$];
        int errors;
        int adds_seen;
        int reads_seen;
        int folds_done;
        int beats_checked;

        function new();
            foreach (tile_digest[k]) tile_digest[k] = '0;
            frame_w       = 16'd640;
            frame_h       = 16'd480;
            cols_reg      = 4'd8;
            rows_reg      = 4'd8;
            errors        = 0;
            adds_seen     = 0;
            reads_seen    = 0;
            folds_done    = 0;
            beats_checked = 0;
        endfunction

        // grid sizes out of range are pinned to 1 .. GRID_MAX
        function int unsigned cols_used();
            if (cols_reg == 0) return 1;
            return (cols_reg > GRID_MAX) ? GRID_MAX : cols_reg;
        endfunction

        function int unsigned rows_used();
            if (rows_reg == 0) return 1;
            return (rows_reg > GRID_MAX) ? GRID_MAX : rows_reg;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_FRAME_WIDTH:  frame_w  = v;
                CFG_FRAME_HEIGHT: frame_h  = v;
                CFG_GRID_COLS:    cols_reg = v[GRID_W-1:0];
                CFG_GRID_ROWS:    rows_reg = v[GRID_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(t_kind kind, logic [S_TDATA_W-1:0] d);
            longint ax, ay, aw, ah, tw, th, bx, by, col, row;
            int unsigned cols, rows, slot;
            logic [DIGEST_W-1:0] hash, cur;
            cols = cols_used();
            rows = rows_used();
            if (kind == KIND_ADD) begin
                ax   = longint'($signed(d[X_LSB +: COORD_W]));
                ay   = longint'($signed(d[Y_LSB +: COORD_W]));
                aw   = longint'($signed(d[W_LSB +: COORD_W]));
                ah   = longint'($signed(d[H_LSB +: COORD_W]));
                hash = d[HASH_LSB +: DIGEST_W];
                tw   = longint'(frame_w / cols);
                th   = longint'(frame_h / rows);
                adds_seen++;
                // row-major walk, half-open overlap test
                for (int r = 0; r < rows; r++) begin
                    for (int c = 0; c < cols; c++) begin
                        bx = c * tw;
                        by = r * th;
                        if (!(ax >= bx + tw || bx >= ax + aw ||
                              ay >= by + th || by >= ay + ah)) begin
                            slot = (r * cols + c) & (TILE_SLOTS - 1);
                            cur  = tile_digest[slot];
                            // byte i takes byte i+1, byte 0 wraps to the top
                            tile_digest[slot] = ((cur >> 8) | (cur << (DIGEST_W - 8))) ^ hash;
                            folds_done++;
                        end
                    end
                end
            end else begin
                col = longint'($signed(d[COL_LSB +: COORD_W]));
                row = longint'($signed(d[ROW_LSB +: COORD_W]));
                if (row < 0) row = 0;
                if (col < 0) col = 0;
                if (row >= rows) row = rows - 1;
                if (col >= cols) col = cols - 1;
                slot = (row * cols + col) & (TILE_SLOTS - 1);
                digests_due.push_back(tile_digest[slot]);
                reads_seen++;
            end
        endfunction

        function void check_digest(logic [DIGEST_W-1:0] got);
            logic [DIGEST_W-1:0] want;
            if (digests_due.size() == 0) begin
                errors++;
                $display("%0t: digest beat %h arrived with no read pending", $time, got);
                return;
            end
            want = digests_due.pop_front();
            beats_checked++;
            if (got[63:0] !== want[63:0]) begin
                errors++;
                $display("%0t: digest_lo expected %h actual %h", $time, want[63:0], got[63:0]);
            end
            if (got[127:64] !== want[127:64]) begin
                errors++;
                $display("%0t: digest_mid expected %h actual %h", $time,
                         want[127:64], got[127:64]);
            end
            if (got[159:128] !== want[159:128]) begin
                errors++;
                $display("%0t: digest_hi expected %h actual %h", $time,
                         want[159:128], got[159:128]);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // rect_x, rect_y, rect_w, rect_h, hash_lo, hash_mid, hash_hi, tile_col, tile_row
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // req_type
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // digest_lo, digest_mid, digest_hi
    logic [M_TDATA_W-1:0] m_axis_tdata;

    tile_digest_scoreboard sb = new();

    bit tx_steady = 1'b0;   // sender offers back to back
    bit rx_steady = 1'b0;   // receiver ready apart from the long hold-offs
    int grid_settings = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    tile_digest_accumulator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stalls, two long hold-offs, checking on each beat
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_left;
        int holds_done;
        stall_left = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            // long hold-offs once results flow, so the queue backs up into the input
            if (hold_left == 0 && ((holds_done == 0 && sb.beats_checked >= 30) ||
                                   (holds_done == 1 && sb.beats_checked >= 300))) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 25) stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_digest(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic cfg_write(t_cfg_index idx, logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
    endtask

    // hold the beat until taken, then maybe idle a while
    task automatic offer(t_kind kind, logic [S_TDATA_W-1:0] d);
        int g;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, d);
        g = tx_steady ? 0 : gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    // random background so that fields a beat does not use still toggle
    function automatic logic [S_TDATA_W-1:0] noise_word();
        logic [S_TDATA_W-1:0] d;
        for (int k = 0; k < S_TDATA_W / 32; k++) d[32*k +: 32] = $urandom();
        return d;
    endfunction

    task automatic add_rect(int x, int y, int w, int h, logic [DIGEST_W-1:0] hash);
        logic [S_TDATA_W-1:0] d;
        d = noise_word();
        d[X_LSB +: COORD_W]     = COORD_W'(x);
        d[Y_LSB +: COORD_W]     = COORD_W'(y);
        d[W_LSB +: COORD_W]     = COORD_W'(w);
        d[H_LSB +: COORD_W]     = COORD_W'(h);
        d[HASH_LSB +: DIGEST_W] = hash;
        offer(KIND_ADD, d);
    endtask

    task automatic read_tile(int col, int row);
        logic [S_TDATA_W-1:0] d;
        d = noise_word();
        d[COL_LSB +: COORD_W] = COORD_W'(col);
        d[ROW_LSB +: COORD_W] = COORD_W'(row);
        offer(KIND_READ, d);
    endtask

    // one random request shaped by the current frame and grid
    task automatic random_request();
        t_kind kind;
        logic [S_TDATA_W-1:0] d;
        int unsigned w_px, h_px, cols, rows, p;
        int x, y, w, h, col, row;
        w_px = sb.frame_w;
        h_px = sb.frame_h;
        cols = sb.cols_used();
        rows = sb.rows_used();
        p    = $urandom_range(0, 99);
        if (p < 10) begin
            // noise beat: everything random
            d    = noise_word();
            kind = t_kind'($urandom_range(0, 1));
            offer(kind, d);
        end else if (p < 55) begin
            x = int'($urandom_range(0, w_px)) - int'($urandom_range(0, w_px / 4));
            y = int'($urandom_range(0, h_px)) - int'($urandom_range(0, h_px / 4));
            if ($urandom_range(0, 2) == 0) begin
                // tile-sized shapes hit only a few tiles
                w = $urandom_range(0, w_px / cols + 1);
                h = $urandom_range(0, h_px / rows + 1);
            end else begin
                w = $urandom_range(0, w_px);
                h = $urandom_range(0, h_px);
            end
            add_rect(x, y, w, h, {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        end else begin
            col = $urandom_range(0, cols - 1);
            row = $urandom_range(0, rows - 1);
            // reads just off the grid edge get clamped
            if ($urandom_range(0, 9) == 0) col = int'($urandom_range(0, cols + 2)) - 1;
            if ($urandom_range(0, 9) == 0) row = int'($urandom_range(0, rows + 2)) - 1;
            read_tile(col, row);
        end
    endtask

    // let every read come back and any trailing add finish its walk
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.digests_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int unsigned w_px, int unsigned h_px, int unsigned cols,
                             int unsigned rows, int n_items, bit steady);
        drain();
        cfg_write(CFG_FRAME_WIDTH, CFG_W'(w_px));
        cfg_write(CFG_FRAME_HEIGHT, CFG_W'(h_px));
        cfg_write(CFG_GRID_COLS, CFG_W'(cols));
        cfg_write(CFG_GRID_ROWS, CFG_W'(rows));
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        tx_steady = steady;
        rx_steady = steady;
        grid_settings++;
        repeat (n_items) random_request();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        grid_settings = 1;

        // reset grid: 640 x 480 in 8 x 8 tiles of 80 x 60
        read_tile(0, 0);                              // cleared store reads zero
        add_rect(0, 0, 640, 480, {5{32'hA5C3_0F1E}}); // whole frame
        add_rect(0, 0, 1, 1, {DIGEST_W{1'b1}});       // single pixel at the corner
        add_rect(80, 60, 80, 60, {5{$urandom()}});    // exactly one tile
        add_rect(79, 59, 2, 2, {5{$urandom()}});      // straddles four tiles
        add_rect(10, 10, 0, 50, {5{$urandom()}});     // empty width
        add_rect(10, 10, 50, -5, {5{$urandom()}});    // negative height
        add_rect(-32768, -32768, 32767, 32767, {DIGEST_W{1'b1}}); // ends left of the frame
        add_rect(32767, 32767, 32767, 32767, {5{$urandom()}});    // past the far corner
        add_rect(-100, 130, 32767, 1, {5{$urandom()}});           // one full tile row
        add_rect(639, 479, 1, 1, '0);                 // last pixel, zero hash
        add_rect(600, 0, 40, -32768, {5{$urandom()}});
        read_tile(0, 0);
        read_tile(1, 1);
        read_tile(0, 1);
        read_tile(-1, -1);
        read_tile(-32768, 3);
        read_tile(3, 32767);
        read_tile(32767, 32767);
        read_tile(8, 8);
        read_tile(7, 0);
        read_tile(5, 2);

        run_phase(65535, 65535, 8, 8, 120, 1'b0);
        run_phase(1, 1, 1, 1, 100, 1'b1);     // one tile, no idling on either side
        run_phase(100, 37, 3, 5, 130, 1'b0);
        run_phase(7, 5, 8, 8, 80, 1'b0);      // tiles of zero size
        run_phase($urandom_range(1, 65535), $urandom_range(1, 65535), 0, 15, 120, 1'b0);
        run_phase(640, 480, 8, 8, 150, 1'b0);
        repeat (3) begin
            run_phase($urandom_range(0, 1) ? $urandom_range(1, 2000) : $urandom_range(1, 65535),
                      $urandom_range(0, 1) ? $urandom_range(1, 2000) : $urandom_range(1, 65535),
                      $urandom_range(0, 15), $urandom_range(0, 15), 130,
                      $urandom_range(0, 3) == 0);
        end
        drain();

        $display("covered %0d requests (%0d adds, %0d reads) over %0d grid settings",
                 sb.adds_seen + sb.reads_seen, sb.adds_seen, sb.reads_seen, grid_settings);
        $display("%0d tile folds predicted, %0d digest beats compared, %0d mismatches",
                 sb.folds_done, sb.beats_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tile_digest_accumulator verification clean");
        end else begin
            $display("tile_digest_accumulator verification failed");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #3_600_000;
        $display("timeout at %0t with %0d reads outstanding", $time, sb.digests_due.size());
        $display("tile_digest_accumulator verification failed");
        $finish;
    end

endmodule

/* files.f */
design/tda_pkg.sv
design/tda_ram.sv
design/tda_front.sv
design/tda_queue.sv
design/tda_back.sv
design/tile_digest_accumulator.sv
design/tda_checker.sv
verif/tile_digest_accumulator_tb.sv
